FILE: rtl/core/assert_macros.svh
// assertion macros shared by the steering controller modules
// no dependencies; taken in by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checking off while reset is held
`define LFSP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication, checking off while reset is held
`define LFSP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checking off while reset is held
`define LFSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lfsp_pkg.sv
// types, constants and the sensor pattern decoder of the steering controller
// no dependencies
package lfsp_pkg;

    localparam int SENSOR_COUNT = 14;
    localparam int DIV_W        = 48;
    localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
    localparam int DEN_W        = 20;

    localparam logic signed [31:0] DRIVE_LIMIT  = 32'sd25344;
    localparam logic signed [31:0] INTEG_WINDOW = 32'sd23040;
    localparam logic signed [15:0] SUM_LIMIT    = 16'sd32000;
    localparam logic signed [20:0] SPEED_P_Q16  = 21'sd4915;
    localparam logic signed [20:0] MEGA         = 21'sd1000000;
    localparam logic [DIV_W-1:0]   HALF_MEGA    = DIV_W'(500000);
    localparam logic [16:0]        WEIGHT_ONE   = 17'd65536;
    // floor(2^39 / 1e6), reciprocal for the integral scaling
    localparam logic signed [20:0] RECIP_MEGA   = 21'sd549755;

    localparam logic [1:0] OP_SPEED_P = 2'd1;
    localparam logic [1:0] OP_P_ONLY  = 2'd2;
    localparam int         OP_INVERT_BIT = 0;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_DERIV_WGT   = 3'd3,
        CFG_PERIOD      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integral_gain;
        logic [15:0] deriv_gain;
        logic [16:0] deriv_weight;
        logic [15:0] period_us;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic signed [4:0] err;
    } t_dec;

    typedef struct packed {
        logic               hit;
        logic signed [4:0]  err;
        logic signed [15:0] speed;
        logic [1:0]         op;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_P, S_P2, S_PFIN,
        S_I1, S_I2, S_I3,
        S_IR1, S_IR2, S_IR3, S_IR4, S_IR5, S_IR6, S_IR7,
        S_D1, S_D2, S_D3, S_DWAIT,
        S_F1, S_F2, S_F3, S_OUT
    } t_state;

    function automatic t_dec lfsp_decode(input logic [SENSOR_COUNT-1:0] pat);
        t_dec d;
        d.hit = 1'b1;
        d.err = '0;
        case (pat)
            14'b00000000000001: d.err = -5'sd12;
            14'b00000000000011: d.err = -5'sd11;
            14'b00000000000111: d.err = -5'sd10;
            14'b00000000001110: d.err = -5'sd9;
            14'b00000000001100: d.err = -5'sd8;
            14'b00000000011100: d.err = -5'sd7;
            14'b00000000011000: d.err = -5'sd6;
            14'b00000000111000: d.err = -5'sd5;
            14'b00000000110000: d.err = -5'sd4;
            14'b00000001110000: d.err = -5'sd3;
            14'b00000001100000: d.err = -5'sd2;
            14'b00000011100000: d.err = -5'sd1;
            14'b00000011000000: d.err = 5'sd0;
            14'b00000111000000: d.err = 5'sd1;
            14'b00000110000000: d.err = 5'sd2;
            14'b00001110000000: d.err = 5'sd3;
            14'b00001100000000: d.err = 5'sd4;
            14'b00011100000000: d.err = 5'sd5;
            14'b00011000000000: d.err = 5'sd6;
            14'b00111000000000: d.err = 5'sd7;
            14'b00110000000000: d.err = 5'sd8;
            14'b01110000000000: d.err = 5'sd9;
            14'b11100000000000: d.err = 5'sd10;
            14'b11000000000000: d.err = 5'sd11;
            14'b10000000000000: d.err = 5'sd12;
            14'b00000011110000: d.err = -5'sd1;
            14'b00000111111000: d.err = -5'sd1;
            14'b00001111111100: d.err = -5'sd1;
            14'b00011111111110: d.err = -5'sd1;
            14'b00000111100000: d.err = 5'sd0;
            14'b00001111110000: d.err = 5'sd0;
            14'b00011111111000: d.err = 5'sd0;
            14'b00111111111100: d.err = 5'sd0;
            14'b00001111000000: d.err = 5'sd1;
            14'b00011111100000: d.err = 5'sd1;
            14'b00111111110000: d.err = 5'sd1;
            14'b01111111111000: d.err = 5'sd1;
            14'b11111000000001: d.err = -5'sd2;
            14'b11100000000001: d.err = -5'sd1;
            14'b11110000000011: d.err = -5'sd1;
            14'b10000000000001: d.err = 5'sd0;
            14'b11000000000011: d.err = 5'sd0;
            14'b11100000000111: d.err = 5'sd0;
            14'b10000000000111: d.err = -5'sd1;
            14'b11000000001111: d.err = -5'sd1;
            14'b10000000011111: d.err = -5'sd2;
            14'b11000001100000: d.err = -5'sd2;
            14'b10000011100000: d.err = -5'sd1;
            14'b10000011000001: d.err = 5'sd0;
            14'b00000111000001: d.err = 5'sd1;
            14'b10000110000011: d.err = 5'sd2;
            14'b11100001100000: d.err = -5'sd2;
            14'b01100001100000: d.err = -5'sd2;
            14'b10000001100000: d.err = -5'sd2;
            14'b11100011100000: d.err = -5'sd1;
            14'b11000011100000: d.err = -5'sd1;
            14'b01100011000000: d.err = 5'sd0;
            14'b11100011000000: d.err = 5'sd0;
            14'b11000011000000: d.err = 5'sd0;
            14'b10000011000000: d.err = 5'sd0;
            14'b01100111000000: d.err = 5'sd1;
            14'b11100111000000: d.err = 5'sd1;
            14'b11000111000000: d.err = 5'sd1;
            14'b10000111000000: d.err = 5'sd1;
            14'b01100110000000: d.err = 5'sd2;
            14'b11100110000000: d.err = 5'sd2;
            14'b11000110000000: d.err = 5'sd2;
            14'b10000110000000: d.err = 5'sd2;
            14'b10001110000000: d.err = 5'sd3;
            14'b10001100000000: d.err = 5'sd4;
            14'b00000110000110: d.err = 5'sd2;
            14'b00000110000111: d.err = 5'sd2;
            14'b00000110000011: d.err = 5'sd2;
            14'b00000110000001: d.err = 5'sd2;
            14'b00000111000111: d.err = 5'sd1;
            14'b00000111000011: d.err = 5'sd1;
            14'b00000011000110: d.err = 5'sd0;
            14'b00000011000111: d.err = 5'sd0;
            14'b00000011000011: d.err = 5'sd0;
            14'b00000011000001: d.err = 5'sd0;
            14'b00000011100110: d.err = -5'sd1;
            14'b00000011100111: d.err = -5'sd1;
            14'b00000011100011: d.err = -5'sd1;
            14'b00000011100001: d.err = -5'sd1;
            14'b00000001100110: d.err = -5'sd2;
            14'b00000001100111: d.err = -5'sd2;
            14'b00000001100011: d.err = -5'sd2;
            14'b00000001100001: d.err = -5'sd2;
            14'b00000001110001: d.err = -5'sd3;
            14'b00000000110001: d.err = -5'sd4;
            default: begin
                d.hit = 1'b0;
                d.err = '0;
            end
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/core/lfsp_front.sv
// front end: takes items, decodes the sensor pattern, holds a two-entry queue
// depends on lfsp_pkg
`include "assert_macros.svh"

module lfsp_front import lfsp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [SENSOR_COUNT-1:0] i_sensor_pattern,
    input  logic signed [15:0]      i_base_speed,
    input  logic [1:0]              i_operation,
    output logic                    o_q_valid,
    output t_cmd                    o_q_cmd,
    input  logic                    i_q_pop
);

    t_cmd       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       wr_en, rd_en;
    logic [SENSOR_COUNT-1:0] pat;
    t_dec       dec;
    t_cmd       cmd;

    assign o_full    = (r_count == 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_cmd   = r_q[r_rd_ptr];
    assign wr_en     = i_push && !o_full;
    assign rd_en     = i_q_pop && o_q_valid;

    always_comb begin
        pat = i_operation[OP_INVERT_BIT] ? ~i_sensor_pattern : i_sensor_pattern;
        dec = lfsp_decode(pat);
        cmd.hit   = dec.hit;
        cmd.err   = dec.err;
        cmd.speed = i_base_speed;
        cmd.op    = i_operation;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) r_wr_ptr <= !r_wr_ptr;
            if (rd_en) r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(wr_en) - 2'(rd_en);
        end
    end

    `LFSP_ASSERT_RST(a_count_bound, i_clk, i_rst_n, r_count <= 2'd2, "queue count overflow")
    `LFSP_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, wr_en && !rd_en, r_count != 2'd0, "item lost in queue")

endmodule

FILE: rtl/core/lfsp_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on lfsp_pkg
module lfsp_divider import lfsp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic [DIV_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_rem, r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy, r_done;
    logic [DEN_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh = {r_rem, r_num[DIV_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-2:0], fits};
            r_rem <= fits ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/lfsp_back.sv
// back end: sequencer with one shared multiplier and the divider, controller
// state and the result register; depends on lfsp_pkg and lfsp_divider
`include "assert_macros.svh"

module lfsp_back import lfsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_cmd               i_q_cmd,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [4:0]  o_line_error,
    output logic signed [15:0] o_yaw_drive,
    output logic signed [16:0] o_right_setpoint,
    output logic signed [16:0] o_left_setpoint
);

    function automatic logic signed [55:0] round_q16(input logic signed [55:0] v);
        logic [55:0] mag, q;
        mag = v[55] ? 56'(-v) : 56'(v);
        q   = (mag + 56'd32768) >> 16;
        return v[55] ? -$signed(q) : $signed(q);
    endfunction

    t_state             r_state, n_state;
    logic signed [4:0]  r_e, n_e, r_prev_e, n_prev_e;
    logic signed [5:0]  r_diff, n_diff;
    logic signed [15:0] r_s, n_s, r_sum, n_sum;
    logic [1:0]         r_op, n_op;
    logic signed [53:0] r_prod, n_prod, r_acc, n_acc;
    logic signed [31:0] r_p, n_p, r_i, n_i, r_draw, n_draw, r_fd, n_fd;
    logic signed [31:0] r_prev_drive, n_prev_drive;
    logic               r_dneg, n_dneg;
    logic               r_out_valid, n_out_valid;
    logic signed [4:0]  r_o_err, n_o_err;
    logic signed [15:0] r_o_yaw, n_o_yaw;
    logic signed [16:0] r_o_right, n_o_right, r_o_left, n_o_left;

    logic signed [32:0] mul_a;
    logic signed [20:0] mul_b;
    logic               div_start, div_busy, div_done;
    logic [DIV_W-1:0]   div_num, div_quot;
    logic [DEN_W-1:0]   div_den;

    logic [15:0]        period;
    logic [16:0]        weight;
    logic [53:0]        prod_mag;

    assign period   = (i_cfg.period_us == 16'd0) ? 16'd1 : i_cfg.period_us;
    assign weight   = (i_cfg.deriv_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg.deriv_weight;
    assign prod_mag = r_prod[53] ? 54'(-r_prod) : 54'(r_prod);
    assign n_prod   = mul_a * mul_b;

    assign o_empty          = !r_out_valid;
    assign o_line_error     = r_o_err;
    assign o_yaw_drive      = r_o_yaw;
    assign o_right_setpoint = r_o_right;
    assign o_left_setpoint  = r_o_left;

    lfsp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        logic signed [4:0]  e;
        logic               win, blk_lo, blk_hi;
        logic signed [33:0] dsum;
        logic signed [31:0] drive;
        logic signed [17:0] s18, y18, sp, sm, m;
        logic signed [55:0] fsum;
        logic [31:0]        qi;

        n_state      = r_state;
        n_e          = r_e;
        n_prev_e     = r_prev_e;
        n_diff       = r_diff;
        n_s          = r_s;
        n_sum        = r_sum;
        n_op         = r_op;
        n_acc        = r_acc;
        n_p          = r_p;
        n_i          = r_i;
        n_draw       = r_draw;
        n_fd         = r_fd;
        n_prev_drive = r_prev_drive;
        n_dneg       = r_dneg;
        n_out_valid  = r_out_valid && !i_pop;
        n_o_err      = r_o_err;
        n_o_yaw      = r_o_yaw;
        n_o_right    = r_o_right;
        n_o_left     = r_o_left;
        o_q_pop      = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_num      = prod_mag[DIV_W-1:0] + DIV_W'(period >> 1);
        div_den      = DEN_W'(period);
        e            = i_q_cmd.hit ? i_q_cmd.err : r_prev_e;
        win          = (r_prev_drive > -INTEG_WINDOW) && (r_prev_drive < INTEG_WINDOW);
        blk_lo       = (r_sum < -SUM_LIMIT) && (e < 0);
        blk_hi       = (r_sum > SUM_LIMIT) && (e > 0);
        dsum         = 34'(r_p) + 34'(r_i) + 34'(r_fd);
        drive        = (dsum[33:31] == 3'b000 || dsum[33:31] == 3'b111) ? dsum[31:0]
                     : (dsum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        y18          = (drive > DRIVE_LIMIT) ? 18'(DRIVE_LIMIT)
                     : (drive < -DRIVE_LIMIT) ? 18'(-DRIVE_LIMIT) : 18'(drive);
        s18          = 18'(r_s);
        sp           = s18 + y18;
        sm           = s18 - y18;
        m            = s18;
        fsum         = 56'(r_acc) + 56'(r_prod);
        qi           = r_i + 32'(r_acc >= 54'(MEGA));

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_e      = e;
                    n_diff   = 6'(e) - 6'(r_prev_e);
                    n_prev_e = e;
                    n_s      = i_q_cmd.speed;
                    n_op     = i_q_cmd.op;
                    if (win && !blk_lo && !blk_hi) n_sum = r_sum + 16'(e);
                    n_state  = S_P;
                end
            end
            S_P: begin
                mul_b = 21'(r_e);
                if (r_op == OP_SPEED_P) begin
                    mul_a   = 33'(r_s);
                    n_state = S_P2;
                end else begin
                    mul_a   = $signed({17'd0, i_cfg.prop_gain});
                    n_state = S_PFIN;
                end
            end
            S_P2: begin
                mul_a   = r_prod[32:0];
                mul_b   = SPEED_P_Q16;
                n_state = S_PFIN;
            end
            S_PFIN: begin
                n_p = (r_op == OP_SPEED_P) ? 32'(round_q16(56'(r_prod))) : r_prod[31:0];
                if (r_op == OP_SPEED_P || r_op == OP_P_ONLY) begin
                    n_i     = '0;
                    n_draw  = '0;
                    n_state = S_F1;
                end else begin
                    n_state = S_I1;
                end
            end
            S_I1: begin
                mul_a   = $signed({17'd0, i_cfg.integral_gain});
                mul_b   = 21'(r_sum);
                n_state = S_I2;
            end
            S_I2: begin
                mul_a   = r_prod[32:0];
                mul_b   = $signed({5'd0, period});
                n_state = S_I3;
            end
            // rounded magnitude numerator, below 2^47
            S_I3: begin
                n_acc   = $signed(prod_mag + 54'(HALF_MEGA));
                n_dneg  = r_prod[53];
                n_state = S_IR1;
            end
            // first quotient estimate from the top 32 bits, low by at most a few hundred
            S_IR1: begin
                mul_a   = $signed({1'b0, r_acc[46:15]});
                mul_b   = RECIP_MEGA;
                n_state = S_IR2;
            end
            S_IR2: begin
                n_i     = $signed({4'd0, r_prod[51:24]});
                mul_a   = $signed({5'd0, r_prod[51:24]});
                mul_b   = MEGA;
                n_state = S_IR3;
            end
            S_IR3: begin
                n_acc   = r_acc - r_prod;
                n_state = S_IR4;
            end
            // second estimate on the remainder, low by at most one
            S_IR4: begin
                mul_a   = $signed({5'd0, r_acc[27:0]});
                mul_b   = RECIP_MEGA;
                n_state = S_IR5;
            end
            S_IR5: begin
                n_i     = r_i + 32'(r_prod[47:39]);
                mul_a   = $signed({24'd0, r_prod[47:39]});
                mul_b   = MEGA;
                n_state = S_IR6;
            end
            S_IR6: begin
                n_acc   = r_acc - r_prod;
                n_state = S_IR7;
            end
            S_IR7: begin
                n_i     = r_dneg ? -$signed(qi) : $signed(qi);
                n_state = S_D1;
            end
            S_D1: begin
                mul_a   = $signed({17'd0, i_cfg.deriv_gain});
                mul_b   = 21'(r_diff);
                n_state = S_D2;
            end
            S_D2: begin
                mul_a   = r_prod[32:0];
                mul_b   = MEGA;
                n_state = S_D3;
            end
            S_D3: begin
                div_start = 1'b1;
                n_dneg    = r_prod[53];
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    if (!r_dneg) begin
                        n_draw = (div_quot > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                               : $signed(div_quot[31:0]);
                    end else begin
                        n_draw = (div_quot > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000
                               : -$signed(div_quot[31:0]);
                    end
                    n_state = S_F1;
                end
            end
            S_F1: begin
                mul_a   = 33'(r_draw);
                mul_b   = $signed({4'd0, weight});
                n_state = S_F2;
            end
            S_F2: begin
                n_acc   = r_prod;
                mul_a   = 33'(r_fd);
                mul_b   = $signed({3'd0, 18'(WEIGHT_ONE) - 18'(weight)});
                n_state = S_F3;
            end
            S_F3: begin
                n_fd    = 32'(round_q16(fsum));
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_pop) begin
                    if (sp > 18'(DRIVE_LIMIT)) begin
                        m = s18 - (sp - 18'(DRIVE_LIMIT));
                    end else if (sm < 18'(-DRIVE_LIMIT)) begin
                        m = s18 - (sm + 18'(DRIVE_LIMIT));
                    end
                    n_prev_drive = drive;
                    n_out_valid  = 1'b1;
                    n_o_err      = r_e;
                    n_o_yaw      = y18[15:0];
                    n_o_right    = 17'(m - y18);
                    n_o_left     = 17'(m + y18);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_prev_e     <= '0;
            r_sum        <= '0;
            r_prev_drive <= '0;
            r_fd         <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_prev_e     <= n_prev_e;
            r_sum        <= n_sum;
            r_prev_drive <= n_prev_drive;
            r_fd         <= n_fd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e       <= n_e;
        r_diff    <= n_diff;
        r_s       <= n_s;
        r_op      <= n_op;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_p       <= n_p;
        r_i       <= n_i;
        r_draw    <= n_draw;
        r_dneg    <= n_dneg;
        r_o_err   <= n_o_err;
        r_o_yaw   <= n_o_yaw;
        r_o_right <= n_o_right;
        r_o_left  <= n_o_left;
    end

    `LFSP_ASSERT_IMPL(a_div_idle, i_clk, i_rst_n, r_state == S_IDLE, !div_busy, "divider busy while sequencer idle")
    `LFSP_ASSERT_RST(a_sum_range, i_clk, i_rst_n, r_sum >= -16'sd32012 && r_sum <= 16'sd32012, "error sum out of range")
    `LFSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_state == S_OUT && r_out_valid && !i_pop, r_state == S_OUT, "result overwrote a waiting item")

endmodule

FILE: rtl/core/line_follow_steering_pid.sv
// top level of the line follower steering controller
// depends on lfsp_pkg, lfsp_front, lfsp_back (and lfsp_divider below it)

// Steering PID for a line-following robot. Items go in through a queue-like
// push/full port and results come out through an empty/pop port, one result
// per item, in order. The front end decodes the 14-bit sensor pattern as the
// item is taken and parks it in a two-entry queue; with the item the back end
// is working on and one finished result, up to four items are held while the
// output side stalls. The back end runs one item at a time on a single 33x21
// multiplier: mode 1 (speed-scaled P) and mode 2 (P only) skip the
// integral and the derivative division; full PID (modes 0 and 3) spends
// most of its time in the bit-serial division of the derivative by the
// period; the integral scaling by period/1e6 is a reciprocal multiply with two
// correction passes. A result waiting on pop holds the back end in S_OUT.
// Gains and filter weight are written through i_cfg_we/i_cfg_idx/i_cfg_data
// and must only change while the block holds no item.
module line_follow_steering_pid import lfsp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration writes
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [16:0]             i_cfg_data,
    // item input
    input  logic                    push,
    output logic                    full,
    input  logic [SENSOR_COUNT-1:0] i_sensor_pattern,
    input  logic signed [15:0]      i_base_speed,
    input  logic [1:0]              i_operation,
    // result output
    output logic                    empty,
    input  logic                    pop,
    output logic signed [4:0]       o_line_error,
    output logic signed [15:0]      o_yaw_drive,
    output logic signed [16:0]      o_right_setpoint,
    output logic signed [16:0]      o_left_setpoint
);

    t_cfg r_cfg;
    logic q_valid, q_pop;
    t_cmd q_cmd;

    // register file; indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= 16'd0;
            r_cfg.integral_gain <= 16'd0;
            r_cfg.deriv_gain    <= 16'd0;
            r_cfg.deriv_weight  <= 17'd0;
            r_cfg.period_us     <= 16'd1000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PROP_GAIN:  r_cfg.prop_gain     <= i_cfg_data[15:0];
                CFG_INTEG_GAIN: r_cfg.integral_gain <= i_cfg_data[15:0];
                CFG_DERIV_GAIN: r_cfg.deriv_gain    <= i_cfg_data[15:0];
                CFG_DERIV_WGT:  r_cfg.deriv_weight  <= i_cfg_data;
                CFG_PERIOD:     r_cfg.period_us     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // decode and buffer
    lfsp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_sensor_pattern (i_sensor_pattern),
        .i_base_speed     (i_base_speed),
        .i_operation      (i_operation),
        .o_q_valid        (q_valid),
        .o_q_cmd          (q_cmd),
        .i_q_pop          (q_pop)
    );

    // arithmetic sequencer and result register
    lfsp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (q_valid),
        .i_q_cmd          (q_cmd),
        .o_q_pop          (q_pop),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_line_error     (o_line_error),
        .o_yaw_drive      (o_yaw_drive),
        .o_right_setpoint (o_right_setpoint),
        .o_left_setpoint  (o_left_setpoint)
    );

endmodule

FILE: tb/lfsp_checker.sv
// checker for the line follower steering controller: predicts each result
// from the accepted items and config writes, compares in order
// depends on lfsp_pkg only
module lfsp_checker import lfsp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [13:0]        i_sensor_pattern,
    input  logic signed [15:0] i_base_speed,
    input  logic [1:0]         i_operation,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [4:0]  i_line_error,
    input  logic signed [15:0] i_yaw_drive,
    input  logic signed [16:0] i_right_setpoint,
    input  logic signed [16:0] i_left_setpoint,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [4:0]  err;
        logic signed [15:0] yaw;
        logic signed [16:0] right;
        logic signed [16:0] left;
    } t_steer;

    localparam logic [13:0] LINE_PAT [90] = '{
        14'b00000000000001, 14'b00000000000011, 14'b00000000000111, 14'b00000000001110,
        14'b00000000001100, 14'b00000000011100, 14'b00000000011000, 14'b00000000111000,
        14'b00000000110000, 14'b00000001110000, 14'b00000001100000, 14'b00000011100000,
        14'b00000011000000, 14'b00000111000000, 14'b00000110000000, 14'b00001110000000,
        14'b00001100000000, 14'b00011100000000, 14'b00011000000000, 14'b00111000000000,
        14'b00110000000000, 14'b01110000000000, 14'b11100000000000, 14'b11000000000000,
        14'b10000000000000,
        14'b00000011110000, 14'b00000111111000, 14'b00001111111100, 14'b00011111111110,
        14'b00000111100000, 14'b00001111110000, 14'b00011111111000, 14'b00111111111100,
        14'b00001111000000, 14'b00011111100000, 14'b00111111110000, 14'b01111111111000,
        14'b11111000000001, 14'b11100000000001, 14'b11110000000011, 14'b10000000000001,
        14'b11000000000011, 14'b11100000000111, 14'b10000000000111, 14'b11000000001111,
        14'b10000000011111, 14'b11000001100000, 14'b10000011100000, 14'b10000011000001,
        14'b00000111000001, 14'b10000110000011,
        14'b11100001100000, 14'b01100001100000, 14'b10000001100000, 14'b11100011100000,
        14'b11000011100000, 14'b01100011000000, 14'b11100011000000, 14'b11000011000000,
        14'b10000011000000, 14'b01100111000000, 14'b11100111000000, 14'b11000111000000,
        14'b10000111000000, 14'b01100110000000, 14'b11100110000000, 14'b11000110000000,
        14'b10000110000000, 14'b10001110000000, 14'b10001100000000,
        14'b00000110000110, 14'b00000110000111, 14'b00000110000011, 14'b00000110000001,
        14'b00000111000111, 14'b00000111000011,
        14'b00000011000110, 14'b00000011000111, 14'b00000011000011, 14'b00000011000001,
        14'b00000011100110, 14'b00000011100111, 14'b00000011100011, 14'b00000011100001,
        14'b00000001100110, 14'b00000001100111, 14'b00000001100011, 14'b00000001100001,
        14'b00000001110001, 14'b00000000110001
    };
    localparam int LINE_ERR [90] = '{
        -12, -11, -10, -9, -8, -7, -6, -5, -4, -3, -2, -1, 0, 1, 2, 3, 4, 5, 6, 7, 8,
        9, 10, 11, 12,
        -1, -1, -1, -1, 0, 0, 0, 0, 1, 1, 1, 1,
        -2, -1, -1, 0, 0, 0, -1, -1, -2, -2, -1, 0, 1, 2,
        -2, -2, -2, -1, -1, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2, 3, 4,
        2, 2, 2, 2, 1, 1, 0, 0, 0, 0, -1, -1, -1, -1, -2, -2, -2, -2, -3, -4
    };

    // controller copy of the config and state
    longint kp, ki, kd, wgt, period;
    longint last_err, err_sum, last_drive, filt_deriv;
    t_steer steer_q [$];

    function automatic longint div_round(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic steer_update(input logic [13:0] pat_in, input logic signed [15:0] speed,
                                input logic [1:0] op);
        logic [13:0] pat;
        longint e, s, p, i, d, drive, y, m, t, a;
        t_steer r;
        pat = op[OP_INVERT_BIT] ? ~pat_in : pat_in;
        s = speed;
        e = last_err;
        foreach (LINE_PAT[k]) if (LINE_PAT[k] == pat) e = LINE_ERR[k];
        if (last_drive > -23040 && last_drive < 23040 &&
            !(err_sum < -32000 && e < 0) && !(err_sum > 32000 && e > 0))
            err_sum = err_sum + e;
        t = (period == 0) ? 1 : period;
        a = (wgt > 65536) ? 65536 : wgt;
        i = 0;
        d = 0;
        if (op == OP_SPEED_P) begin
            p = div_round(s * e * 4915, 65536);
        end else if (op == OP_P_ONLY) begin
            p = kp * e;
        end else begin
            p = kp * e;
            i = div_round(ki * err_sum * t, 1000000);
            d = clip32(div_round(kd * (e - last_err) * 1000000, t));
        end
        d = div_round(a * d + (65536 - a) * filt_deriv, 65536);
        filt_deriv = d;
        drive = clip32(p + i + d);
        last_drive = drive;
        last_err = e;
        y = drive;
        if (y > 25344) y = 25344;
        else if (y < -25344) y = -25344;
        m = s;
        if (s + y > 25344) m = m - (s + y - 25344);
        else if (s - y < -25344) m = m - (s - y + 25344);
        r.err = e[4:0];
        r.yaw = y[15:0];
        r.right = 17'(m - y);
        r.left = 17'(m + y);
        steer_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_steer want;
        if (!i_rst_n) begin
            kp = 0; ki = 0; kd = 0; wgt = 0; period = 1000;
            last_err = 0; err_sum = 0; last_drive = 0; filt_deriv = 0;
            steer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:  kp = i_cfg_data[15:0];
                    CFG_INTEG_GAIN: ki = i_cfg_data[15:0];
                    CFG_DERIV_GAIN: kd = i_cfg_data[15:0];
                    CFG_DERIV_WGT:  wgt = i_cfg_data;
                    CFG_PERIOD:     period = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (steer_q.size() == 0) begin
                    if (o_fail_count < 10) $display("result with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = steer_q.pop_front();
                    if (want !== {i_line_error, i_yaw_drive, i_right_setpoint,
                                  i_left_setpoint}) begin
                        if (o_fail_count < 10)
                            $display("mismatch err %0d/%0d yaw %0d/%0d right %0d/%0d left %0d/%0d",
                                     want.err, i_line_error, want.yaw, i_yaw_drive,
                                     want.right, i_right_setpoint, want.left, i_left_setpoint);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_push && !i_full)
                steer_update(i_sensor_pattern, i_base_speed, i_operation);
        end
        o_pending <= steer_q.size();
    end
endmodule

FILE: tb/testbench.sv
// top of the steering controller testbench: clock, reset, stimulus, verdict
// depends on lfsp_pkg, lfsp_checker and line_follow_steering_pid
module testbench import lfsp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [16:0]        i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic [13:0]        i_sensor_pattern = '0;
    logic signed [15:0] i_base_speed = '0;
    logic [1:0]         i_operation = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [4:0]  o_line_error;
    logic signed [15:0] o_yaw_drive;
    logic signed [16:0] o_right_setpoint;
    logic signed [16:0] o_left_setpoint;
    int                 fail_count;
    int                 pending;

    // idle stage: 0 sender light / receiver heavy, 1 reversed, 2 no idling
    int  idle_stage = 0;
    int  items_sent = 0;
    bit  hold_done = 0;
    int  quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    line_follow_steering_pid dut (.*);

    lfsp_checker checker_u (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_push(push), .i_full(full), .i_sensor_pattern, .i_base_speed, .i_operation,
        .i_empty(empty), .i_pop(pop), .i_line_error(o_line_error),
        .i_yaw_drive(o_yaw_drive), .i_right_setpoint(o_right_setpoint),
        .i_left_setpoint(o_left_setpoint), .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random pop with one long hold-off so the input queue fills
    initial begin
        int pct;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_sent >= 60) begin
                hold_done = 1;
                pop = 1'b0;
                repeat (500) @(negedge i_clk);
            end
            pct = (idle_stage == 0) ? 64 : (idle_stage == 1) ? 16 : 0;
            pop = ($urandom_range(0, 99) >= pct);
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [16:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic cfg_all(input logic [16:0] kp, ki, kd, w, t);
        cfg_write(CFG_PROP_GAIN, kp);
        cfg_write(CFG_INTEG_GAIN, ki);
        cfg_write(CFG_DERIV_GAIN, kd);
        cfg_write(CFG_DERIV_WGT, w);
        cfg_write(CFG_PERIOD, t);
    endtask

    // offer one item and hold it until taken; called just after a falling edge
    task automatic send_item(input logic [13:0] pat, input logic signed [15:0] spd,
                             input logic [1:0] op);
        int pct;
        pct = (idle_stage == 0) ? 16 : (idle_stage == 1) ? 64 : 0;
        while ($urandom_range(0, 99) < pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_sensor_pattern = pat;
        i_base_speed = spd;
        i_operation = op;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (items_sent == 650) idle_stage = 1;
        if (items_sent == 1300) idle_stage = 2;
        @(negedge i_clk);
    endtask

    // drain and let the back end go quiet before touching config
    task automatic settle();
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // mostly a bar of one to three sensors, some wide bars, some noise
    task automatic random_item();
        logic [13:0] pat;
        logic signed [15:0] spd;
        logic [1:0] op;
        int w, pos, sel;
        sel = $urandom_range(0, 99);
        op = 2'($urandom_range(0, 3));
        if (sel < 70) begin
            w = $urandom_range(1, 3);
            pos = $urandom_range(0, 14 - w);
            pat = ((14'h1 << w) - 14'h1) << pos;
        end else if (sel < 85) begin
            w = $urandom_range(4, 12);
            pos = $urandom_range(0, 14 - w);
            pat = ((14'h1 << w) - 14'h1) << pos;
        end else begin
            pat = 14'($urandom);
        end
        if (op[0] && sel < 85) pat = ~pat;
        if ($urandom_range(0, 9) == 0) spd = 16'($urandom);
        else spd = 16'($urandom_range(0, 50688) - 25344);
        send_item(pat, spd, op);
    endtask

    initial begin
        logic [13:0] dpat [12];
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, every mode, unknown pattern holding
        cfg_all(17'd256, 17'd16, 17'd32, 17'd32768, 17'd1000);
        dpat = '{14'h0001, 14'h2000, 14'h0000, 14'h3fff, 14'h00c0, 14'h1555,
                 14'h0003, 14'h3000, 14'h2aaa, 14'h0031, 14'h3e01, 14'h01c0};
        foreach (dpat[k]) send_item(dpat[k], 16'sd25344, 2'(k));
        send_item(14'h0001, -16'sd25344, 2'd0);
        send_item(14'h2000, 16'sd32767, 2'd1);
        send_item(14'h0001, -16'sd32768, 2'd1);
        send_item(~14'h2000, 16'sd0, 2'd3);
        send_item(14'h1234, 16'sd100, 2'd2);
        send_item(14'h3ffe, -16'sd25344, 2'd1);
        send_item(14'h0000, 16'sd25344, 2'd3);
        settle();

        // several settings, extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: cfg_all(17'($urandom_range(0, 1024)), 17'($urandom_range(0, 256)),
                           17'($urandom_range(0, 256)), 17'($urandom_range(0, 65536)),
                           17'd1000);
                1: cfg_all(17'd65535, 17'd65535, 17'd65535, 17'd65536, 17'd65535);
                2: cfg_all(17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
                3: cfg_all(17'($urandom_range(0, 2048)), 17'($urandom_range(0, 2048)),
                           17'($urandom_range(0, 64)), 17'd131071, 17'd1);
                4: cfg_all(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                           17'($urandom));
                default: cfg_all(17'($urandom_range(0, 512)), 17'($urandom_range(0, 4096)),
                                 17'($urandom_range(0, 512)), 17'($urandom_range(1, 65535)),
                                 17'($urandom_range(1, 5000)));
            endcase
            repeat (322) random_item();
            settle();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
